/* rtl/sfrc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the SPI flash request chunker.
// No dependencies; used by the controller, the datapath and the top level.
package sfrc_pkg;

   localparam int ADDR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Request kinds
   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_PROGRAM = 2'd1;
   localparam logic [1:0] KIND_ERASE   = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // Result status codes
   localparam logic [1:0] ST_CMD   = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_OOB   = 2'd2;
   localparam logic [1:0] ST_TRUNC = 2'd3;

   // SPI command bytes
   localparam logic [7:0] OP_NONE       = 8'h00;
   localparam logic [7:0] OP_READ       = 8'h03;
   localparam logic [7:0] OP_PROGRAM    = 8'h02;
   localparam logic [7:0] OP_AAI_WORD   = 8'hAD;
   localparam logic [7:0] OP_CHIP_ERASE = 8'hC7;

   // Address byte counts
   localparam logic [2:0] ABYTES_NONE  = 3'd0;
   localparam logic [2:0] ABYTES_THREE = 3'd3;
   localparam logic [2:0] ABYTES_FOUR  = 3'd4;

   // Capacities above this need four address bytes
   localparam logic [ADDR_W-1:0] FOUR_BYTE_LIMIT = 32'h0100_0000;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY        = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASER_SIZES    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASER_COMMANDS = 2'd3;

   // Configuration reset values
   localparam logic [31:0] RST_CAPACITY        = 32'd16777216;
   localparam logic        RST_WRITE_MODE      = 1'b0;
   localparam logic [31:0] RST_ERASER_SIZES    = 32'd1052428;
   localparam logic [31:0] RST_ERASER_COMMANDS = 32'd14176800;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] start_address;
      logic [31:0]       byte_count;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [7:0]        opcode;
      logic [ADDR_W-1:0] chunk_address;
      logic [2:0]        address_bytes;
      logic [31:0]       chunk_length;
      logic [31:0]       data_offset;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] capacity;
      logic        write_mode;
      logic [31:0] eraser_sizes;
      logic [31:0] eraser_commands;
   } cfg_type;

   // Kind of result the datapath builds
   typedef enum logic [2:0] {
      STEP_SINGLE,
      STEP_PAGE,
      STEP_BYTE,
      STEP_WORD_FIRST,
      STEP_WORD_REST,
      STEP_ERASE
   } step_type;

   // Controller to datapath
   typedef struct packed {
      logic     capture;
      logic     mod_step;
      logic     sel_load;
      logic     emit;
      step_type step;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic single;
      logic is_erase;
      logic page_mode;
      logic start_odd;
      logic rem_ge2;
      logic rem_eq2;
      logic rem_eq3;
      logic slot_free;
      logic mod_done;
      logic run_end;
   } stat_type;

endpackage

/* rtl/spi_flash_request_chunker.sv */
`timescale 1ns / 1ps
// A read, chip erase, empty or out-of-bound request is captured, then its result goes
// into the output register when free. Page programs first find the page offset
// (serially if PAGE_BYTES is not a power of two), then one command per cycle while the
// output is not stalled, like AAI; erase alternates eraser choice and gap arithmetic.
// Up to MAX_RESULTS results per request; the next request is taken the cycle after the
// last one enters the output register. Synchronous reset restores settings and state.
module spi_flash_request_chunker #(
   parameter int MAX_RESULTS  = 64,
   parameter int PAGE_BYTES   = 256,
   parameter int ERASER_TYPES = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  sfrc_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output sfrc_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfrc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_wdata
);
   import sfrc_pkg::*;

   logic [31:0] capacity_ff, capacity_in;
   logic        write_mode_ff, write_mode_in;
   logic [31:0] eraser_sizes_ff, eraser_sizes_in;
   logic [31:0] eraser_commands_ff, eraser_commands_in;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   always_comb begin
      capacity_in        = capacity_ff;
      write_mode_in      = write_mode_ff;
      eraser_sizes_in    = eraser_sizes_ff;
      eraser_commands_in = eraser_commands_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CAPACITY:        capacity_in        = csr_wdata;
            CSR_WRITE_MODE:      write_mode_in      = csr_wdata[0];
            CSR_ERASER_SIZES:    eraser_sizes_in    = csr_wdata;
            CSR_ERASER_COMMANDS: eraser_commands_in = csr_wdata;
            default:             capacity_in        = capacity_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff        <= RST_CAPACITY;
         write_mode_ff      <= RST_WRITE_MODE;
         eraser_sizes_ff    <= RST_ERASER_SIZES;
         eraser_commands_ff <= RST_ERASER_COMMANDS;
      end else begin
         capacity_ff        <= capacity_in;
         write_mode_ff      <= write_mode_in;
         eraser_sizes_ff    <= eraser_sizes_in;
         eraser_commands_ff <= eraser_commands_in;
      end
   end

   assign cfg.capacity        = capacity_ff;
   assign cfg.write_mode      = write_mode_ff;
   assign cfg.eraser_sizes    = eraser_sizes_ff;
   assign cfg.eraser_commands = eraser_commands_ff;

   sfrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sfrc_dp #(
      .MAX_RESULTS  (MAX_RESULTS),
      .PAGE_BYTES   (PAGE_BYTES),
      .ERASER_TYPES (ERASER_TYPES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/sfrc_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer of the SPI flash request chunker: classifies a request and walks
// the command phases. Depends on sfrc_pkg; drives sfrc_dp through cmd_type.
module sfrc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sfrc_pkg::stat_type stat,
   output sfrc_pkg::cmd_type  cmd
);
   import sfrc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_PAGE_MOD,
      S_PAGE,
      S_AAI_LEAD,
      S_AAI_FIRST,
      S_AAI_REST,
      S_AAI_TAIL,
      S_ERASE_SEL,
      S_ERASE_OUT
   } state_type;

   state_type state_ff, state_in;

   // New request only when no run is in flight
   assign req_stall = (state_ff != S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd.capture  = 1'b0;
      cmd.mod_step = 1'b0;
      cmd.sel_load = 1'b0;
      cmd.emit     = 1'b0;
      cmd.step     = STEP_SINGLE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.single) begin
               if (stat.slot_free) begin
                  cmd.emit = 1'b1;
                  state_in = S_IDLE;
               end
            end else if (stat.is_erase) begin
               state_in = S_ERASE_SEL;
            end else if (stat.page_mode) begin
               state_in = S_PAGE_MOD;
            end else if (stat.start_odd) begin
               state_in = S_AAI_LEAD;
            end else if (stat.rem_ge2) begin
               state_in = S_AAI_FIRST;
            end else begin
               state_in = S_AAI_TAIL;
            end
         end
         S_PAGE_MOD: begin
            cmd.mod_step = 1'b1;
            if (stat.mod_done) state_in = S_PAGE;
         end
         S_PAGE: begin
            cmd.step = STEP_PAGE;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (stat.run_end) state_in = S_IDLE;
            end
         end
         S_AAI_LEAD: begin
            cmd.step = STEP_BYTE;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (stat.run_end)      state_in = S_IDLE;
               else if (stat.rem_eq2) state_in = S_AAI_TAIL;
               else                   state_in = S_AAI_FIRST;
            end
         end
         S_AAI_FIRST, S_AAI_REST: begin
            cmd.step = (state_ff == S_AAI_FIRST) ? STEP_WORD_FIRST : STEP_WORD_REST;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               if (stat.run_end)      state_in = S_IDLE;
               else if (stat.rem_eq3) state_in = S_AAI_TAIL;
               else                   state_in = S_AAI_REST;
            end
         end
         S_AAI_TAIL: begin
            cmd.step = STEP_BYTE;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERASE_SEL: begin
            cmd.sel_load = 1'b1;
            state_in     = S_ERASE_OUT;
         end
         S_ERASE_OUT: begin
            cmd.step = STEP_ERASE;
            if (stat.slot_free) begin
               cmd.emit = 1'b1;
               state_in = stat.run_end ? S_IDLE : S_ERASE_SEL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/sfrc_dp.sv */
`timescale 1ns / 1ps
// Datapath of the SPI flash request chunker: run registers, chunk arithmetic,
// eraser choice and the result register. Depends on sfrc_pkg.
module sfrc_dp #(
   parameter int MAX_RESULTS  = 64,
   parameter int PAGE_BYTES   = 256,
   parameter int ERASER_TYPES = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  sfrc_pkg::cfg_type  cfg,
   input  sfrc_pkg::req_type  req_data,
   input  sfrc_pkg::cmd_type  cmd,
   output sfrc_pkg::stat_type stat,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sfrc_pkg::rsp_type  rsp_data
);
   import sfrc_pkg::*;

   localparam int CNT_W     = $clog2(MAX_RESULTS);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_RESULTS - 1);
   localparam int PW        = $clog2(PAGE_BYTES + 1);
   localparam bit PAGE_POW2 = ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0);
   localparam int MOD_CNT_W = $clog2(ADDR_W) + 1;
   localparam int BIT_W     = MOD_CNT_W - 1;

   // Run registers
   logic [1:0]           kind_ff, kind_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          off_ff, off_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [MOD_CNT_W-1:0] mcnt_ff, mcnt_in;
   logic [4:0]           lg_ff, lg_in;
   logic [7:0]           eop_ff, eop_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // Request classification
   logic [2:0]  abytes;
   logic [32:0] end_sum;
   logic        oob, chip, any_eraser, empty, is_read, single;

   assign abytes  = (cfg.capacity > FOUR_BYTE_LIMIT) ? ABYTES_FOUR : ABYTES_THREE;
   assign end_sum = {1'b0, cur_ff} + {1'b0, rem_ff};
   assign oob     = end_sum > {1'b0, cfg.capacity};
   assign chip    = (kind_ff == KIND_ERASE) && (cur_ff == '0) && (rem_ff == cfg.capacity);
   assign empty   = (rem_ff == '0) || (kind_ff == KIND_UNUSED) ||
                    ((kind_ff == KIND_ERASE) && !chip && !any_eraser);
   assign is_read = (kind_ff == KIND_READ);
   assign single  = oob || empty || is_read || chip;

   // Eraser choice: present one in the lowest slot, or the aligned one that fits in the highest slot
   logic [4:0]  small_lg, fit_lg, sel_lg;
   logic [7:0]  small_op, fit_op, sel_op;
   logic        fit_any, small_aligned;

   always_comb begin
      logic [7:0]  lg_byte;
      logic [31:0] lmask;
      any_eraser = 1'b0;
      small_lg   = '0;
      small_op   = '0;
      fit_any    = 1'b0;
      fit_lg     = '0;
      fit_op     = '0;
      for (int i = ERASER_TYPES - 1; i >= 0; i--) begin
         lg_byte = cfg.eraser_sizes[8*i +: 8];
         if (lg_byte != 8'd0 && lg_byte < 8'd32) begin
            any_eraser = 1'b1;
            small_lg   = lg_byte[4:0];
            small_op   = cfg.eraser_commands[8*i +: 8];
         end
      end
      for (int i = 0; i < ERASER_TYPES; i++) begin
         lg_byte = cfg.eraser_sizes[8*i +: 8];
         lmask   = (32'd1 << lg_byte[4:0]) - 32'd1;
         if (lg_byte != 8'd0 && lg_byte < 8'd32 && (rem_ff >> lg_byte[4:0]) != '0 &&
             (cur_ff & lmask) == '0) begin
            fit_any = 1'b1;
            fit_lg  = lg_byte[4:0];
            fit_op  = cfg.eraser_commands[8*i +: 8];
         end
      end
   end

   assign small_aligned = (cur_ff & ((32'd1 << small_lg) - 32'd1)) == '0;
   assign sel_lg        = (small_aligned && fit_any) ? fit_lg : small_lg;
   assign sel_op        = (small_aligned && fit_any) ? fit_op : small_op;

   // Erase chunk: gap to the next boundary of the chosen block
   logic [31:0] e_size, e_gap;
   logic        e_done;

   assign e_size = 32'd1 << lg_ff;
   assign e_gap  = e_size - (cur_ff & (e_size - 32'd1));
   assign e_done = rem_ff <= e_gap;

   // Page chunk: bytes left in the current page
   logic [PW-1:0] room, pos_sum;
   logic [31:0]   room32, p_len;
   logic          p_done;

   assign room    = PW'(PAGE_BYTES) - pos_ff;
   assign room32  = 32'(room);
   assign p_len   = (rem_ff < room32) ? rem_ff : room32;
   assign p_done  = rem_ff <= room32;
   assign pos_sum = pos_ff + p_len[PW-1:0];

   // Serial remainder of the start address by the page size
   logic [BIT_W-1:0] bidx;
   logic [PW:0]      twice;
   logic             mod_done;

   assign bidx     = BIT_W'(ADDR_W - 1) - mcnt_ff[BIT_W-1:0];
   assign twice    = {pos_ff, cur_ff[bidx]};
   assign mod_done = PAGE_POW2 || mcnt_ff[MOD_CNT_W-1];

   // Step length and end of run
   logic rem_eq1, step_done, at_limit, trunc, slot_free;
   logic [31:0] step_len;

   assign rem_eq1 = (rem_ff == 32'd1);

   always_comb begin
      case (cmd.step)
         STEP_PAGE: begin
            step_done = p_done;
            step_len  = p_len;
         end
         STEP_BYTE: begin
            step_done = rem_eq1;
            step_len  = 32'd1;
         end
         STEP_WORD_FIRST, STEP_WORD_REST: begin
            step_done = stat.rem_eq2;
            step_len  = 32'd2;
         end
         STEP_ERASE: begin
            step_done = e_done;
            step_len  = e_gap;
         end
         default: begin
            step_done = 1'b1;
            step_len  = '0;
         end
      endcase
   end

   assign at_limit  = (cnt_ff == LIMIT);
   assign trunc     = at_limit && !step_done;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Result payload
   always_comb begin
      rsp_in.status        = ST_CMD;
      rsp_in.opcode        = OP_NONE;
      rsp_in.chunk_address = cur_ff;
      rsp_in.address_bytes = abytes;
      rsp_in.chunk_length  = rem_ff;
      rsp_in.data_offset   = off_ff;
      rsp_in.last          = step_done;
      case (cmd.step)
         STEP_SINGLE: begin
            rsp_in.data_offset   = '0;
            rsp_in.last          = 1'b1;
            rsp_in.address_bytes = ABYTES_NONE;
            if (oob) begin
               rsp_in.status = ST_OOB;
            end else if (empty) begin
               rsp_in.status = ST_EMPTY;
            end else if (is_read) begin
               rsp_in.opcode        = OP_READ;
               rsp_in.address_bytes = abytes;
            end else begin
               rsp_in.opcode        = OP_CHIP_ERASE;
               rsp_in.chunk_address = '0;
            end
         end
         STEP_PAGE: begin
            rsp_in.opcode       = OP_PROGRAM;
            rsp_in.chunk_length = p_len;
         end
         STEP_BYTE: begin
            rsp_in.opcode       = OP_PROGRAM;
            rsp_in.chunk_length = 32'd1;
         end
         STEP_WORD_FIRST: begin
            rsp_in.opcode       = OP_AAI_WORD;
            rsp_in.chunk_length = 32'd2;
         end
         STEP_WORD_REST: begin
            rsp_in.opcode        = OP_AAI_WORD;
            rsp_in.chunk_length  = 32'd2;
            rsp_in.chunk_address = '0;
            rsp_in.address_bytes = ABYTES_NONE;
         end
         STEP_ERASE: begin
            rsp_in.opcode       = eop_ff;
            rsp_in.chunk_length = e_size;
         end
         default: rsp_in.opcode = OP_NONE;
      endcase
      // Run cut short: report what is left
      if (cmd.step != STEP_SINGLE && trunc) begin
         rsp_in.status        = ST_TRUNC;
         rsp_in.opcode        = OP_NONE;
         rsp_in.chunk_address = cur_ff;
         rsp_in.address_bytes = ABYTES_NONE;
         rsp_in.chunk_length  = rem_ff;
         rsp_in.data_offset   = off_ff;
         rsp_in.last          = 1'b1;
      end
   end

   // Register next values
   always_comb begin
      kind_in = kind_ff;
      cur_in  = cur_ff;
      rem_in  = rem_ff;
      off_in  = off_ff;
      cnt_in  = cnt_ff;
      pos_in  = pos_ff;
      mcnt_in = mcnt_ff;
      lg_in   = lg_ff;
      eop_in  = eop_ff;
      if (cmd.capture) begin
         kind_in = req_data.kind;
         cur_in  = req_data.start_address;
         rem_in  = req_data.byte_count;
         off_in  = '0;
         cnt_in  = '0;
         mcnt_in = '0;
         pos_in  = PAGE_POW2 ?
                   PW'(req_data.start_address & ADDR_W'(PAGE_BYTES - 1)) : '0;
      end
      if (cmd.mod_step && !mod_done) begin
         pos_in  = (twice >= (PW+1)'(PAGE_BYTES)) ?
                   PW'(twice - (PW+1)'(PAGE_BYTES)) : PW'(twice);
         mcnt_in = mcnt_ff + MOD_CNT_W'(1);
      end
      if (cmd.sel_load) begin
         lg_in  = sel_lg;
         eop_in = sel_op;
      end
      if (cmd.emit && cmd.step != STEP_SINGLE) begin
         cnt_in = cnt_ff + CNT_W'(1);
         cur_in = cur_ff + step_len;
         rem_in = rem_ff - step_len;
         off_in = off_ff + step_len;
         if (cmd.step == STEP_PAGE) begin
            pos_in = (pos_sum == PW'(PAGE_BYTES)) ? '0 : pos_sum;
         end
      end
   end

   // Output register: refilled as soon as the held transfer goes out
   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cur_ff  <= cur_in;
      rem_ff  <= rem_in;
      off_ff  <= off_in;
      cnt_ff  <= cnt_in;
      pos_ff  <= pos_in;
      mcnt_ff <= mcnt_in;
      lg_ff   <= lg_in;
      eop_ff  <= eop_in;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status to the sequencer
   assign stat.single    = single;
   assign stat.is_erase  = (kind_ff == KIND_ERASE);
   assign stat.page_mode = !cfg.write_mode;
   assign stat.start_odd = cur_ff[0];
   assign stat.rem_ge2   = (rem_ff > 32'd1);
   assign stat.rem_eq2   = (rem_ff == 32'd2);
   assign stat.rem_eq3   = (rem_ff == 32'd3);
   assign stat.slot_free = slot_free;
   assign stat.mod_done  = mod_done;
   assign stat.run_end   = step_done || at_limit;

endmodule

/* dv/tb_spi_flash_request_chunker.sv */
`timescale 1ns / 1ps
// Self-checking testbench for spi_flash_request_chunker: directed and random requests
// under several register settings, with random result stalls and request gaps. Needs sfrc_pkg.
module tb_spi_flash_request_chunker;
   import sfrc_pkg::*;

   localparam int MAX_CHUNKS   = 64;
   localparam int PAGE_SIZE    = 256;
   localparam int ERASER_SLOTS = 4;
   localparam int HOLD_CYCLES  = 400;

   typedef enum logic [2:0] {
      RUN_IDLE,
      RUN_PAGE,
      RUN_AAI_LEAD,
      RUN_AAI_FIRST,
      RUN_AAI_REST,
      RUN_AAI_TAIL,
      RUN_ERASE
   } run_phase_e;

   // Expected command chunks per accepted request, checked in order
   class chunk_tracker;
      rsp_type     expected_chunks[$];
      int          errors;
      logic [31:0] capacity;
      logic        write_mode;
      logic [31:0] eraser_sizes;
      logic [31:0] eraser_commands;

      function new();
         errors          = 0;
         capacity        = RST_CAPACITY;
         write_mode      = RST_WRITE_MODE;
         eraser_sizes    = RST_ERASER_SIZES;
         eraser_commands = RST_ERASER_COMMANDS;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
         case (idx)
            CSR_CAPACITY:        capacity = value;
            CSR_WRITE_MODE:      write_mode = value[0];
            CSR_ERASER_SIZES:    eraser_sizes = value;
            CSR_ERASER_COMMANDS: eraser_commands = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_chunks.size();
      endfunction

      function logic [2:0] addr_width();
         return (capacity > FOUR_BYTE_LIMIT) ? ABYTES_FOUR : ABYTES_THREE;
      endfunction

      // Size bytes of 32 and up mean no eraser in that slot
      function logic [31:0] eraser_log(int i);
         logic [7:0] v;
         v = eraser_sizes[8*i +: 8];
         return (v >= 8'd32) ? 32'd0 : {24'd0, v};
      endfunction

      function int first_eraser();
         for (int i = 0; i < ERASER_SLOTS; i++)
            if (eraser_log(i) != 0) return i;
         return -1;
      endfunction

      function void note_request(req_type r);
         rsp_type     c;
         logic [31:0] addr, rem, start, count, len, room, size, gap, lg, sz;
         logic [31:0] save_addr, save_rem;
         logic [32:0] span;
         logic        chip;
         run_phase_e  phase;
         int          n, idx, i;
         start = r.start_address;
         count = r.byte_count;
         c.status        = ST_CMD;
         c.opcode        = OP_NONE;
         c.chunk_address = start;
         c.address_bytes = ABYTES_NONE;
         c.chunk_length  = count;
         c.data_offset   = 32'd0;
         c.last          = 1'b1;
         span = {1'b0, start} + {1'b0, count};
         chip = (r.kind == KIND_ERASE) && (start == 0) && (count == capacity);

         // Single-result requests
         if (span > {1'b0, capacity}) begin
            c.status = ST_OOB;
            expected_chunks.push_back(c);
            return;
         end
         if (count == 0 || r.kind == KIND_UNUSED ||
             (r.kind == KIND_ERASE && !chip && first_eraser() < 0)) begin
            c.status = ST_EMPTY;
            expected_chunks.push_back(c);
            return;
         end
         if (r.kind == KIND_READ) begin
            c.opcode        = OP_READ;
            c.address_bytes = addr_width();
            expected_chunks.push_back(c);
            return;
         end
         if (chip) begin
            c.opcode        = OP_CHIP_ERASE;
            c.chunk_address = 32'd0;
            expected_chunks.push_back(c);
            return;
         end

         if (r.kind == KIND_ERASE) phase = RUN_ERASE;
         else if (!write_mode) phase = RUN_PAGE;
         else if (start[0]) phase = RUN_AAI_LEAD;
         else phase = (count >= 2) ? RUN_AAI_FIRST : RUN_AAI_TAIL;

         addr = start;
         rem  = count;
         n    = 0;
         while (phase != RUN_IDLE) begin
            save_addr = addr;
            save_rem  = rem;
            c.status        = ST_CMD;
            c.chunk_address = addr;
            c.address_bytes = addr_width();
            c.data_offset   = addr - start;
            case (phase)
               RUN_PAGE: begin
                  room = PAGE_SIZE - (addr % PAGE_SIZE);
                  len  = (rem < room) ? rem : room;
                  c.opcode       = OP_PROGRAM;
                  c.chunk_length = len;
                  addr += len;
                  rem  -= len;
                  if (rem == 0) phase = RUN_IDLE;
               end
               RUN_AAI_LEAD: begin
                  c.opcode       = OP_PROGRAM;
                  c.chunk_length = 32'd1;
                  addr += 1;
                  rem  -= 1;
                  if (rem >= 2) phase = RUN_AAI_FIRST;
                  else if (rem == 1) phase = RUN_AAI_TAIL;
                  else phase = RUN_IDLE;
               end
               RUN_AAI_FIRST, RUN_AAI_REST: begin
                  c.opcode       = OP_AAI_WORD;
                  c.chunk_length = 32'd2;
                  // later words go out without an address
                  if (phase == RUN_AAI_REST) begin
                     c.chunk_address = 32'd0;
                     c.address_bytes = ABYTES_NONE;
                  end
                  addr += 2;
                  rem  -= 2;
                  if (rem >= 2) phase = RUN_AAI_REST;
                  else if (rem == 1) phase = RUN_AAI_TAIL;
                  else phase = RUN_IDLE;
               end
               RUN_AAI_TAIL: begin
                  c.opcode       = OP_PROGRAM;
                  c.chunk_length = 32'd1;
                  addr += 1;
                  rem  -= 1;
                  phase = RUN_IDLE;
               end
               default: begin
                  // eraser in the lowest slot unless aligned, then the aligned one that fits in the highest slot
                  idx  = first_eraser();
                  size = 32'd1 << eraser_log(idx);
                  if (addr % size == 0) begin
                     for (i = ERASER_SLOTS - 1; i >= 0; i--) begin
                        lg = eraser_log(i);
                        if (lg != 0) begin
                           sz = 32'd1 << lg;
                           if (rem >= sz && addr % sz == 0) begin
                              idx  = i;
                              size = sz;
                              break;
                           end
                        end
                     end
                  end
                  c.opcode       = eraser_commands[8*idx +: 8];
                  c.chunk_length = size;
                  gap = size - (addr % size);
                  if (rem > gap) begin
                     rem  -= gap;
                     addr += gap;
                  end else begin
                     phase = RUN_IDLE;
                  end
               end
            endcase
            // Out of result slots with work left: close with a truncation marker
            if (n >= MAX_CHUNKS - 1 && phase != RUN_IDLE) begin
               c.status        = ST_TRUNC;
               c.opcode        = OP_NONE;
               c.chunk_address = save_addr;
               c.address_bytes = ABYTES_NONE;
               c.chunk_length  = save_rem;
               c.data_offset   = save_addr - start;
               c.last          = 1'b1;
               expected_chunks.push_back(c);
               phase = RUN_IDLE;
            end else begin
               c.last = (phase == RUN_IDLE);
               expected_chunks.push_back(c);
               n++;
            end
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_chunks.size() == 0) begin
            $error("result with nothing expected: status %0d opcode %02h address %08h",
                   got.status, got.opcode, got.chunk_address);
            errors++;
            return;
         end
         want = expected_chunks.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("opcode", want.opcode, got.opcode);
         compare_field("chunk_address", want.chunk_address, got.chunk_address);
         compare_field("address_bytes", want.address_bytes, got.address_bytes);
         compare_field("chunk_length", want.chunk_length, got.chunk_length);
         compare_field("data_offset", want.data_offset, got.data_offset);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   logic                 clock;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   chunk_tracker chunks;
   bit           quiet            = 1'b0;
   bit           hold_off_request = 1'b0;
   logic [31:0]  current_capacity = RST_CAPACITY;

   spi_flash_request_chunker #(
      .MAX_RESULTS  (MAX_CHUNKS),
      .PAGE_BYTES   (PAGE_SIZE),
      .ERASER_TYPES (ERASER_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_spi_flash_request_chunker: done, errors");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off whenever requested
   initial begin : rsp_stall_driver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_off_request) begin
            hold_left        = HOLD_CYCLES;
            hold_off_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 15);
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         chunks.check_result(rsp_data);
   end

   function automatic req_type request_of(logic [1:0] k, logic [31:0] a, logic [31:0] n);
      req_type r;
      r.kind          = k;
      r.start_address = a;
      r.byte_count    = n;
      return r;
   endfunction

   // Mostly in-bound requests of varied size, with some noise
   function automatic req_type gen_request(logic [31:0] cap);
      req_type     r;
      int          sel, pick;
      logic [31:0] cnt, mask;
      sel  = $urandom_range(0, 99);
      pick = $urandom_range(0, 99);
      r.kind = (sel < 20) ? KIND_READ : (sel < 55) ? KIND_PROGRAM :
               (sel < 93) ? KIND_ERASE : KIND_UNUSED;
      if (pick < 8) begin
         r.start_address = $urandom;
         r.byte_count    = $urandom;
      end else if (pick < 12) begin
         r.start_address = $urandom_range(0, cap);
         r.byte_count    = 32'd0;
      end else if (pick < 17) begin
         // whole device
         if ($urandom_range(0, 2) != 0) r.kind = KIND_ERASE;
         r.start_address = 32'd0;
         r.byte_count    = cap;
      end else if (pick < 22) begin
         r.start_address = $urandom_range(0, cap);
         r.byte_count    = cap - r.start_address;
      end else if (pick < 32) begin
         r.start_address = $urandom_range(0, cap);
         r.byte_count    = $urandom_range(0, cap - r.start_address);
      end else begin
         cnt = $urandom_range(0, 1) ? $urandom_range(1, 600) : $urandom_range(1, 32'h4_0000);
         if (cnt > cap) cnt = cap;
         r.start_address = $urandom_range(0, cap - cnt);
         if ($urandom_range(0, 1)) begin
            mask = (32'd1 << $urandom_range(1, 20)) - 32'd1;
            r.start_address &= ~mask;
         end
         r.byte_count = cnt;
      end
      return r;
   endfunction

   function automatic logic [31:0] gen_eraser_sizes();
      logic [31:0] v;
      int          t;
      for (int b = 0; b < 4; b++) begin
         t = $urandom_range(0, 9);
         v[8*b +: 8] = (t < 2) ? 8'd0 : (t < 8) ? 8'($urandom_range(1, 20))
                                                : 8'($urandom_range(32, 255));
      end
      return v;
   endfunction

   function automatic logic [31:0] gen_capacity();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return FOUR_BYTE_LIMIT;
         2: return FOUR_BYTE_LIMIT + 32'd1;
         3: return $urandom_range(1, 32'h10_0000);
         4: return 32'hFFFF_FFFF;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Present one request, with random idle cycles ahead of it
   task automatic send_request(input req_type item);
      while (!quiet && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      chunks.note_request(item);
   endtask

   task automatic drain();
      while (chunks.pending() != 0) @(posedge clock);
   endtask

   // Program all four registers once the block has gone idle
   task automatic apply_settings(input logic [31:0] cap, input logic [31:0] mode,
                                 input logic [31:0] sizes, input logic [31:0] cmds);
      logic [31:0]          vals[4];
      logic [CSR_IDX_W-1:0] regs[4];
      int                   i;
      vals = '{cap, mode, sizes, cmds};
      regs = '{CSR_CAPACITY, CSR_WRITE_MODE, CSR_ERASER_SIZES, CSR_ERASER_COMMANDS};
      drain();
      repeat (4) @(posedge clock);
      for (i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         do @(posedge clock); while (!csr_ready);
         chunks.set_register(regs[i], vals[i]);
      end
      csr_valid <= 1'b0;
      current_capacity = cap;
   endtask

   task automatic run_random(input int count, input int hold_at,
                             input int quiet_from, input int quiet_to);
      for (int k = 0; k < count; k++) begin
         if (k == hold_at) hold_off_request = 1'b1;
         quiet = (k >= quiet_from) && (k < quiet_to);
         send_request(gen_request(current_capacity));
      end
      quiet = 1'b0;
      req_valid <= 1'b0;
   endtask

   initial begin : stimulus
      chunks = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default geometry: 16 MiB, page program, 4K/32K/64K erasers
      apply_settings(RST_CAPACITY, RST_WRITE_MODE, RST_ERASER_SIZES, RST_ERASER_COMMANDS);
      send_request(request_of(KIND_READ, 32'd0, 32'd1));
      send_request(request_of(KIND_READ, 32'h00FF_FFFF, 32'd1));
      send_request(request_of(KIND_READ, 32'd0, RST_CAPACITY));
      send_request(request_of(KIND_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_request(request_of(KIND_PROGRAM, RST_CAPACITY, 32'd1));
      send_request(request_of(KIND_PROGRAM, 32'h100, 32'd0));
      send_request(request_of(KIND_UNUSED, 32'h10, 32'd16));
      send_request(request_of(KIND_PROGRAM, 32'h10, 32'd300));
      send_request(request_of(KIND_PROGRAM, 32'd0, 32'd16384));
      send_request(request_of(KIND_PROGRAM, 32'd0, 32'd16385));
      send_request(request_of(KIND_PROGRAM, 32'h00FF_FF00, 32'd256));
      send_request(request_of(KIND_ERASE, 32'd0, RST_CAPACITY));
      send_request(request_of(KIND_ERASE, 32'h1234, 32'h100));
      send_request(request_of(KIND_ERASE, 32'd0, 32'h2_1000));
      send_request(request_of(KIND_ERASE, 32'd0, RST_CAPACITY - 32'd1));
      req_valid <= 1'b0;

      // 4 GiB less one byte, AAI, one size byte out of range
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1028_0C00, 32'hD877_2055);
      send_request(request_of(KIND_PROGRAM, 32'h1001, 32'd1));
      send_request(request_of(KIND_PROGRAM, 32'h1001, 32'd2));
      send_request(request_of(KIND_PROGRAM, 32'h1000, 32'd1));
      send_request(request_of(KIND_PROGRAM, 32'h1000, 32'd5));
      send_request(request_of(KIND_PROGRAM, 32'hFFFF_FFF1, 32'd6));
      send_request(request_of(KIND_PROGRAM, 32'd1, 32'd200));
      send_request(request_of(KIND_ERASE, 32'h10, 32'h3000));
      send_request(request_of(KIND_READ, 32'hFFFF_FFFE, 32'd1));
      req_valid <= 1'b0;

      // No usable eraser: only chip erase works
      apply_settings(32'd4096, 32'd0, 32'hFF20_0000, 32'h0000_0000);
      send_request(request_of(KIND_ERASE, 32'd0, 32'd100));
      send_request(request_of(KIND_ERASE, 32'd0, 32'd4096));
      req_valid <= 1'b0;

      // Tiny erasers, just past the three-byte address limit
      apply_settings(FOUR_BYTE_LIMIT + 32'd1, 32'd1, 32'h0302_0100, 32'hFFA5_5A01);
      send_request(request_of(KIND_ERASE, 32'd3, 32'd13));
      send_request(request_of(KIND_ERASE, FOUR_BYTE_LIMIT, 32'd1));
      req_valid <= 1'b0;

      // Random traffic: long receiver hold-off, then a stretch without idling
      apply_settings(RST_CAPACITY, 32'd0, RST_ERASER_SIZES, RST_ERASER_COMMANDS);
      run_random(70, 10, -1, -1);
      apply_settings(32'hFFFF_FFFF, 32'd1, 32'h1410_0C01, $urandom);
      run_random(70, -1, 15, 60);
      for (int p = 0; p < 5; p++) begin
         apply_settings(gen_capacity(), $urandom, gen_eraser_sizes(), $urandom);
         run_random(30, (p == 2) ? 5 : -1, -1, -1);
      end

      drain();
      repeat (20) @(posedge clock);
      if (chunks.errors == 0 && chunks.pending() == 0)
         $display("tb_spi_flash_request_chunker: done, clean");
      else
         $display("tb_spi_flash_request_chunker: done, errors");
      $finish;
   end

endmodule
